// ===== rtl/core/l4hfe_pkg.sv =====
// Package: constants, codes and payload types for the L4 header field extractor.
package l4hfe_pkg;

    localparam int BATCH_RECORDS = 16;
    localparam int CNT_W = (BATCH_RECORDS > 1) ? $clog2(BATCH_RECORDS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BATCH_RECORDS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    // IP version codes as reported
    localparam logic [2:0] VER_NONE = 3'd0;
    localparam logic [2:0] VER_V4   = 3'd4;
    localparam logic [2:0] VER_V6   = 3'd6;
    localparam logic [3:0] NIB_V4   = 4'd4;
    localparam logic [3:0] NIB_V6   = 4'd6;

    // descriptor packet type that is recorded
    localparam logic [3:0] KIND_IP  = 4'd0;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP6_ECHO_REQUEST = 8'd128;
    localparam logic [7:0] ICMP6_ECHO_REPLY   = 8'd129;

    // header byte offsets
    localparam logic [POS_W-1:0] V4_LEN_HI   = 6'd2;
    localparam logic [POS_W-1:0] V4_LEN_LO   = 6'd3;
    localparam logic [POS_W-1:0] V4_ID_HI    = 6'd4;
    localparam logic [POS_W-1:0] V4_ID_LO    = 6'd5;
    localparam logic [POS_W-1:0] V4_PROTO    = 6'd9;
    localparam logic [POS_W-1:0] V4_L4_START = 6'd20;
    localparam logic [POS_W-1:0] V6_LEN_HI   = 6'd4;
    localparam logic [POS_W-1:0] V6_LEN_LO   = 6'd5;
    localparam logic [POS_W-1:0] V6_NEXT_HDR = 6'd6;
    localparam logic [POS_W-1:0] V6_L4_START = 6'd40;

    localparam int L4_BYTES = 12;
    localparam logic [POS_W-1:0] L4_SPAN = 6'd12;
    localparam logic [16:0] V6_HDR_LEN = 17'd40;

    // configuration register map (word index)
    localparam int PADDR_W = 3;
    localparam logic CFG_IDX_CAPTURE = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] user_tag;
        logic       maa_owned;
        logic [3:0] packet_kind;
    } l4hfe_in_t;

    typedef struct packed {
        logic [2:0]  ip_version;
        logic [7:0]  l4_protocol;
        logic [15:0] ipv4_ident;
        logic [16:0] total_length;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] flow_id;
        logic [31:0] ack_or_sequence;
        logic [7:0]  icmp_kind;
        logic [7:0]  user_tag_out;
        logic        batch_end;
    } l4hfe_out_t;

    // raw header capture handed from front to back
    typedef struct packed {
        logic [2:0]              version;
        logic [7:0]              protocol;
        logic [15:0]             ident;
        logic [15:0]             length;
        logic [L4_BYTES*8-1:0]   l4;
        logic [7:0]              tag;
    } l4hfe_capture_t;

endpackage

// ===== rtl/core/l4hfe_front.sv =====
// Front end: tracks byte position, filters packets and captures header bytes.
module l4hfe_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      capture_enable,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  l4hfe_pkg::l4hfe_in_t      s_payload,
    input  logic                      q_full,
    output logic                      q_push,
    output l4hfe_pkg::l4hfe_capture_t q_data
);

    logic [l4hfe_pkg::POS_W-1:0] pos_reg, pos_next, pos_base;
    logic                        wanted_reg, wanted_next, wanted_base;
    l4hfe_pkg::l4hfe_capture_t   cap_reg, cap_next, cap_base;
    logic [l4hfe_pkg::POS_W-1:0] l4_off;
    logic                        l4_hit;
    logic [7:0]                  b;

    assign s_ready = !q_full;
    assign b       = s_payload.data_byte;

    always_comb begin
        if (s_payload.first_byte) begin
            pos_base        = '0;
            cap_base        = '0;
            cap_base.tag    = s_payload.user_tag;
            wanted_base     = capture_enable && !s_payload.maa_owned &&
                              (s_payload.packet_kind == l4hfe_pkg::KIND_IP);
        end else begin
            pos_base    = pos_reg;
            cap_base    = cap_reg;
            wanted_base = wanted_reg;
        end
    end

    // offset into the L4 header for the current version
    always_comb begin
        l4_off = '0;
        l4_hit = 1'b0;
        if (cap_base.version == l4hfe_pkg::VER_V4 && pos_base >= l4hfe_pkg::V4_L4_START) begin
            l4_off = pos_base - l4hfe_pkg::V4_L4_START;
            l4_hit = (l4_off < l4hfe_pkg::L4_SPAN);
        end else if (cap_base.version == l4hfe_pkg::VER_V6 &&
                     pos_base >= l4hfe_pkg::V6_L4_START) begin
            l4_off = pos_base - l4hfe_pkg::V6_L4_START;
            l4_hit = (l4_off < l4hfe_pkg::L4_SPAN);
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        wanted_next = wanted_reg;
        cap_next    = cap_reg;
        q_push      = 1'b0;
        if (s_valid && s_ready) begin
            pos_next    = pos_base;
            wanted_next = wanted_base;
            cap_next    = cap_base;
            if (wanted_base) begin
                if (pos_base == '0) begin
                    if (b[7:4] == l4hfe_pkg::NIB_V4) begin
                        cap_next.version = l4hfe_pkg::VER_V4;
                    end else if (b[7:4] == l4hfe_pkg::NIB_V6) begin
                        cap_next.version = l4hfe_pkg::VER_V6;
                    end else begin
                        cap_next.version = l4hfe_pkg::VER_NONE;
                    end
                end else if (cap_base.version == l4hfe_pkg::VER_V4) begin
                    if (pos_base == l4hfe_pkg::V4_LEN_HI) cap_next.length[15:8] = b;
                    if (pos_base == l4hfe_pkg::V4_LEN_LO) cap_next.length[7:0]  = b;
                    if (pos_base == l4hfe_pkg::V4_ID_HI)  cap_next.ident[15:8]  = b;
                    if (pos_base == l4hfe_pkg::V4_ID_LO)  cap_next.ident[7:0]   = b;
                    if (pos_base == l4hfe_pkg::V4_PROTO)  cap_next.protocol     = b;
                end else if (cap_base.version == l4hfe_pkg::VER_V6) begin
                    if (pos_base == l4hfe_pkg::V6_LEN_HI)   cap_next.length[15:8] = b;
                    if (pos_base == l4hfe_pkg::V6_LEN_LO)   cap_next.length[7:0]  = b;
                    if (pos_base == l4hfe_pkg::V6_NEXT_HDR) cap_next.protocol     = b;
                end
                for (int i = 0; i < l4hfe_pkg::L4_BYTES; i++) begin
                    if (l4_hit && l4_off == l4hfe_pkg::POS_W'(i)) begin
                        cap_next.l4[(l4hfe_pkg::L4_BYTES-1-i)*8 +: 8] = b;
                    end
                end
                if (pos_base != l4hfe_pkg::POS_MAX) begin
                    pos_next = pos_base + 1'b1;
                end
                if (s_payload.last_byte) begin
                    wanted_next = 1'b0;
                    q_push      = 1'b1;
                end
            end
        end
    end

    assign q_data = cap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            wanted_reg <= 1'b0;
            cap_reg    <= '0;
        end else begin
            pos_reg    <= pos_next;
            wanted_reg <= wanted_next;
            cap_reg    <= cap_next;
        end
    end

endmodule

// ===== rtl/core/l4hfe_queue.sv =====
// Short FIFO of captured headers between front and back.
module l4hfe_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  l4hfe_pkg::l4hfe_capture_t push_data,
    output logic                      full,
    input  logic                      pop,
    output logic                      head_valid,
    output l4hfe_pkg::l4hfe_capture_t head_data
);

    l4hfe_pkg::l4hfe_capture_t       mem [l4hfe_pkg::QUEUE_DEPTH];
    logic [l4hfe_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [l4hfe_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [l4hfe_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = (count_reg == l4hfe_pkg::QCNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == l4hfe_pkg::QPTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == l4hfe_pkg::QPTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/l4hfe_back.sv =====
// Back end: formats the log record, counts batches and holds the output register.
module l4hfe_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  l4hfe_pkg::l4hfe_capture_t q_data,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output l4hfe_pkg::l4hfe_out_t     m_payload
);

    logic                        m_valid_reg, m_valid_next;
    l4hfe_pkg::l4hfe_out_t       rec_reg, rec;
    logic [l4hfe_pkg::CNT_W-1:0] count_reg, count_next;
    logic [31:0]                 w0, w1, tail;
    logic [7:0]                  itype;
    logic                        is_echo;

    assign w0    = q_data.l4[95:64];
    assign w1    = q_data.l4[63:32];
    assign tail  = q_data.l4[31:0];
    assign itype = w0[31:24];
    assign is_echo = (itype == l4hfe_pkg::ICMP_ECHO_REPLY) ||
                     (itype == l4hfe_pkg::ICMP_ECHO_REQUEST) ||
                     (itype == l4hfe_pkg::ICMP6_ECHO_REQUEST) ||
                     (itype == l4hfe_pkg::ICMP6_ECHO_REPLY);

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        rec = '0;
        if (q_data.version == l4hfe_pkg::VER_V4 || q_data.version == l4hfe_pkg::VER_V6) begin
            rec.ip_version  = q_data.version;
            rec.l4_protocol = q_data.protocol;
            if (q_data.version == l4hfe_pkg::VER_V4) begin
                rec.ipv4_ident   = q_data.ident;
                rec.total_length = {1'b0, q_data.length};
            end else begin
                rec.total_length = {1'b0, q_data.length} + l4hfe_pkg::V6_HDR_LEN;
            end
            priority if (q_data.protocol == l4hfe_pkg::PROTO_TCP) begin
                rec.source_port     = w0[31:16];
                rec.dest_port       = w0[15:0];
                rec.flow_id         = w1;
                rec.ack_or_sequence = tail;
            end else if (q_data.protocol == l4hfe_pkg::PROTO_UDP) begin
                rec.source_port = w0[31:16];
                rec.dest_port   = w0[15:0];
            end else if (q_data.protocol == l4hfe_pkg::PROTO_ICMP ||
                         q_data.protocol == l4hfe_pkg::PROTO_ICMPV6) begin
                rec.icmp_kind = itype;
                if (is_echo) begin
                    rec.flow_id         = {16'd0, w1[31:16]};
                    rec.ack_or_sequence = {16'd0, w1[15:0]};
                end
            end else begin
                rec.flow_id         = w0;
                rec.ack_or_sequence = w1;
            end
            rec.user_tag_out = q_data.tag;
        end
        rec.batch_end = (count_reg == l4hfe_pkg::CNT_LAST);
    end

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop) begin
            m_valid_next = 1'b1;
            count_next   = (count_reg == l4hfe_pkg::CNT_LAST) ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rec_reg <= rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = rec_reg;

endmodule

// ===== rtl/core/ip_l4_header_field_extractor_top.sv =====
// Top level: config register, front end, capture queue and record back end.
//
//  port group   dir  handshake          carries
//  s_*          in   s_valid/s_ready    one packet byte with its markers and metadata
//  m_*          out  m_valid/m_ready    one log record per recorded packet
//  p*           in   psel/penable       capture_enable register at word 0
//
// One byte accepted per cycle while the capture queue has room; a record passes from the
// front capture into the queue, then into the back end output register.
// s_ready drops only while the two-entry capture queue is full, i.e. when the
// back end is stalled by m_ready with two records already waiting.
// Synchronous active-low reset clears position, filter state, queue and batch count.
module ip_l4_header_field_extractor_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  l4hfe_pkg::l4hfe_in_t            s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output l4hfe_pkg::l4hfe_out_t           m_payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [l4hfe_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic                      capture_enable_reg, capture_enable_next;
    logic                      q_push, q_full, q_pop, q_valid;
    l4hfe_pkg::l4hfe_capture_t q_in, q_head;
    logic                      cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == l4hfe_pkg::CFG_IDX_CAPTURE) && (paddr[1:0] == 2'b00);

    always_comb begin
        capture_enable_next = capture_enable_reg;
        if (psel && penable && pwrite && pready && cfg_hit) begin
            capture_enable_next = pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_hit) begin
            prdata = {31'd0, capture_enable_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_enable_reg <= 1'b0;
        end else begin
            capture_enable_reg <= capture_enable_next;
        end
    end

    l4hfe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .capture_enable (capture_enable_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    l4hfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    l4hfe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // no request may be pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("capture queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("capture queue underflow");

    // a non-IP record carries nothing but the batch flag
    a_non_ip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.ip_version != l4hfe_pkg::VER_V4 &&
         m_payload.ip_version != l4hfe_pkg::VER_V6) |->
        (m_payload.user_tag_out == 8'd0 && m_payload.total_length == 17'd0 &&
         m_payload.flow_id == 32'd0 && m_payload.source_port == 16'd0))
        else $error("non-IP record not cleared");

    a_v6_no_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.ip_version == l4hfe_pkg::VER_V6) |->
        (m_payload.ipv4_ident == 16'd0 && m_payload.total_length >= 17'd40))
        else $error("IPv6 record carries IPv4 fields");

endmodule

// ===== tb/sv/tb_ip_l4_header_field_extractor_top.sv =====
// Testbench for the L4 header field extractor: random packet traffic against a field predictor.
module tb_ip_l4_header_field_extractor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [l4hfe_pkg::PADDR_W-1:0] CAPTURE_ADDR =
        l4hfe_pkg::PADDR_W'({l4hfe_pkg::CFG_IDX_CAPTURE, 2'b00});
    localparam int NUM_FIELDS = 11;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

    logic                            aclk;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    l4hfe_pkg::l4hfe_in_t            s_payload = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    l4hfe_pkg::l4hfe_out_t           m_payload;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [l4hfe_pkg::PADDR_W-1:0]   paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    ip_l4_header_field_extractor_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // stimulus and expected records
    l4hfe_pkg::l4hfe_in_t  byte_q[$];
    l4hfe_pkg::l4hfe_out_t pending_records[$];
    logic       byte_taken = 1'b0;
    logic       calm = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         err_cnt = 0;
    int         bytes_seen = 0;
    int         recs_seen = 0;
    int         batches_seen = 0;

    // predictor copy of the block state
    logic        cap_en_m = 1'b0;
    logic [5:0]  at_pos = '0;
    logic        in_packet = 1'b0;
    logic [7:0]  tag_m = '0;
    logic [2:0]  ver_m = '0;
    logic [7:0]  proto_m = '0;
    logic [15:0] ident_m = '0;
    logic [16:0] len_m = '0;
    logic [63:0] l4_head = '0;
    logic [31:0] l4_tail = '0;
    int          rec_cnt = 0;

    string fld_name [0:NUM_FIELDS-1] = '{"ip_version", "l4_protocol", "ipv4_ident",
        "total_length", "source_port", "dest_port", "flow_id", "ack_or_sequence",
        "icmp_kind", "user_tag_out", "batch_end"};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic take_l4(input logic [5:0] k, input logic [7:0] b);
        int ki;
        ki = k;
        if (ki < 8)
            l4_head[(7 - ki) * 8 +: 8] = b;
        else if (ki < l4hfe_pkg::L4_BYTES)
            l4_tail[(11 - ki) * 8 +: 8] = b;
    endtask

    // Advance the predictor by one accepted byte; queue the record it completes.
    task automatic parse_byte(input l4hfe_pkg::l4hfe_in_t it);
        l4hfe_pkg::l4hfe_out_t rec;
        logic [7:0]  b;
        logic [31:0] w0;
        logic [31:0] w1;
        b = it.data_byte;
        if (it.first_byte) begin
            at_pos = '0;
            ver_m = l4hfe_pkg::VER_NONE;
            proto_m = '0;
            ident_m = '0;
            len_m = '0;
            l4_head = '0;
            l4_tail = '0;
            in_packet = cap_en_m && !it.maa_owned && it.packet_kind == l4hfe_pkg::KIND_IP;
            tag_m = it.user_tag;
        end
        if (!in_packet)
            return;

        if (at_pos == '0) begin
            ver_m = (b[7:4] == l4hfe_pkg::NIB_V4) ? l4hfe_pkg::VER_V4 :
                    (b[7:4] == l4hfe_pkg::NIB_V6) ? l4hfe_pkg::VER_V6 : l4hfe_pkg::VER_NONE;
        end else if (ver_m == l4hfe_pkg::VER_V4) begin
            case (at_pos)
                l4hfe_pkg::V4_LEN_HI: len_m[15:8] = b;
                l4hfe_pkg::V4_LEN_LO: len_m[7:0] = b;
                l4hfe_pkg::V4_ID_HI:  ident_m[15:8] = b;
                l4hfe_pkg::V4_ID_LO:  ident_m[7:0] = b;
                l4hfe_pkg::V4_PROTO:  proto_m = b;
                default: begin
                    if (at_pos >= l4hfe_pkg::V4_L4_START)
                        take_l4(at_pos - l4hfe_pkg::V4_L4_START, b);
                end
            endcase
        end else if (ver_m == l4hfe_pkg::VER_V6) begin
            case (at_pos)
                l4hfe_pkg::V6_LEN_HI:   len_m[15:8] = b;
                l4hfe_pkg::V6_LEN_LO:   len_m[7:0] = b;
                l4hfe_pkg::V6_NEXT_HDR: proto_m = b;
                default: begin
                    if (at_pos >= l4hfe_pkg::V6_L4_START)
                        take_l4(at_pos - l4hfe_pkg::V6_L4_START, b);
                end
            endcase
        end
        if (at_pos < l4hfe_pkg::POS_MAX)
            at_pos = at_pos + 6'd1;

        if (!it.last_byte)
            return;

        in_packet = 1'b0;
        rec = '0;
        w0 = l4_head[63:32];
        w1 = l4_head[31:0];
        if (ver_m == l4hfe_pkg::VER_V4 || ver_m == l4hfe_pkg::VER_V6) begin
            rec.ip_version = ver_m;
            rec.l4_protocol = proto_m;
            if (ver_m == l4hfe_pkg::VER_V4) begin
                rec.ipv4_ident = ident_m;
                rec.total_length = {1'b0, len_m[15:0]};
            end else begin
                rec.total_length = {1'b0, len_m[15:0]} + l4hfe_pkg::V6_HDR_LEN;
            end
            case (proto_m)
                l4hfe_pkg::PROTO_TCP: begin
                    rec.source_port = w0[31:16];
                    rec.dest_port = w0[15:0];
                    rec.flow_id = w1;
                    rec.ack_or_sequence = l4_tail;
                end
                l4hfe_pkg::PROTO_UDP: begin
                    rec.source_port = w0[31:16];
                    rec.dest_port = w0[15:0];
                end
                l4hfe_pkg::PROTO_ICMP, l4hfe_pkg::PROTO_ICMPV6: begin
                    rec.icmp_kind = w0[31:24];
                    // only echo types carry id / sequence
                    case (w0[31:24])
                        l4hfe_pkg::ICMP_ECHO_REPLY, l4hfe_pkg::ICMP_ECHO_REQUEST,
                        l4hfe_pkg::ICMP6_ECHO_REQUEST, l4hfe_pkg::ICMP6_ECHO_REPLY: begin
                            rec.flow_id = {16'h0, w1[31:16]};
                            rec.ack_or_sequence = {16'h0, w1[15:0]};
                        end
                        default: ;
                    endcase
                end
                default: begin
                    rec.flow_id = w0;
                    rec.ack_or_sequence = w1;
                end
            endcase
            rec.user_tag_out = tag_m;
        end
        rec_cnt++;
        if (rec_cnt >= l4hfe_pkg::BATCH_RECORDS) begin
            rec_cnt = 0;
            rec.batch_end = 1'b1;
        end
        pending_records.push_back(rec);
    endtask

    function automatic logic [31:0] rec_field(input l4hfe_pkg::l4hfe_out_t r, input int i);
        case (i)
            0:  return 32'(r.ip_version);
            1:  return 32'(r.l4_protocol);
            2:  return 32'(r.ipv4_ident);
            3:  return 32'(r.total_length);
            4:  return 32'(r.source_port);
            5:  return 32'(r.dest_port);
            6:  return r.flow_id;
            7:  return r.ack_or_sequence;
            8:  return 32'(r.icmp_kind);
            9:  return 32'(r.user_tag_out);
            default: return 32'(r.batch_end);
        endcase
    endfunction

    task automatic compare_record(input l4hfe_pkg::l4hfe_out_t want,
                                  input l4hfe_pkg::l4hfe_out_t got);
        for (int i = 0; i < NUM_FIELDS; i++) begin
            if (rec_field(want, i) !== rec_field(got, i)) begin
                err_cnt++;
                $display("%0t: record %0d field %s expected %0h actual %0h", $time,
                         recs_seen, fld_name[i], rec_field(want, i), rec_field(got, i));
            end
        end
    endtask

    // sampling side: config shadow, record check, request prediction
    always @(posedge aclk) begin
        byte_taken = 1'b0;
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == CAPTURE_ADDR)
                cap_en_m = pwdata[0];
            if (m_valid && m_ready) begin
                if (pending_records.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected record, expected none actual %0h", $time,
                             m_payload);
                end else begin
                    compare_record(pending_records.pop_front(), m_payload);
                end
                recs_seen++;
                if (m_payload.batch_end)
                    batches_seen++;
            end
            if (s_valid && s_ready) begin
                byte_taken = 1'b1;
                bytes_seen++;
                parse_byte(s_payload);
            end
        end
    end

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (gap_left > 0 && !calm) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 12) - 1;
                s_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                s_payload <= byte_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // record sink backpressure
    always @(negedge aclk) begin
        if (!aresetn || calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_item(input logic [7:0] data, input logic first, input logic last,
                             input logic [7:0] tag, input logic maa, input logic [3:0] kind);
        l4hfe_pkg::l4hfe_in_t it;
        it.data_byte = data;
        it.first_byte = first;
        it.last_byte = last;
        it.user_tag = tag;
        it.maa_owned = maa;
        it.packet_kind = kind;
        byte_q.push_back(it);
    endtask

    // Build one packet of n bytes; metadata on later bytes is random since it is ignored.
    task automatic queue_packet(input logic [2:0] ver, input logic [7:0] proto,
                                input logic [7:0] icmp_t, input int n, input fill_t fill,
                                input logic [7:0] tag, input logic maa,
                                input logic [3:0] kind, input logic close);
        logic [7:0] pk [0:79];
        for (int i = 0; i < 80; i++)
            pk[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
        case (ver)
            l4hfe_pkg::VER_V4: begin
                pk[0][7:4] = l4hfe_pkg::NIB_V4;
                pk[l4hfe_pkg::V4_PROTO] = proto;
                if (proto == l4hfe_pkg::PROTO_ICMP || proto == l4hfe_pkg::PROTO_ICMPV6)
                    pk[l4hfe_pkg::V4_L4_START] = icmp_t;
            end
            l4hfe_pkg::VER_V6: begin
                pk[0][7:4] = l4hfe_pkg::NIB_V6;
                pk[l4hfe_pkg::V6_NEXT_HDR] = proto;
                if (proto == l4hfe_pkg::PROTO_ICMP || proto == l4hfe_pkg::PROTO_ICMPV6)
                    pk[l4hfe_pkg::V6_L4_START] = icmp_t;
            end
            default: begin
                while (pk[0][7:4] == l4hfe_pkg::NIB_V4 || pk[0][7:4] == l4hfe_pkg::NIB_V6)
                    pk[0][7:4] = 4'($urandom);
            end
        endcase
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                push_item(pk[i], 1'b1, close && n == 1, tag, maa, kind);
            else
                push_item(pk[i], 1'b0, close && i == n - 1, 8'($urandom), 1'($urandom),
                          4'($urandom));
        end
    endtask

    // Random packets until about target bytes of recordable packets are queued.
    task automatic random_traffic(input int target);
        int counted;
        int r;
        int n;
        int full;
        logic [2:0] ver;
        logic [7:0] proto;
        logic [7:0] icmp_t;
        logic maa;
        logic [3:0] kind;
        logic close;
        fill_t fill;
        counted = 0;
        while (counted < target) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ver = l4hfe_pkg::VER_V4;
                4, 5, 6, 7: ver = l4hfe_pkg::VER_V6;
                default:    ver = l4hfe_pkg::VER_NONE;
            endcase
            case ($urandom_range(0, 4))
                0: proto = l4hfe_pkg::PROTO_ICMP;
                1: proto = l4hfe_pkg::PROTO_TCP;
                2: proto = l4hfe_pkg::PROTO_UDP;
                3: proto = l4hfe_pkg::PROTO_ICMPV6;
                default: proto = 8'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: icmp_t = l4hfe_pkg::ICMP_ECHO_REPLY;
                1: icmp_t = l4hfe_pkg::ICMP_ECHO_REQUEST;
                2: icmp_t = l4hfe_pkg::ICMP6_ECHO_REQUEST;
                3: icmp_t = l4hfe_pkg::ICMP6_ECHO_REPLY;
                default: icmp_t = 8'($urandom);
            endcase
            case ($urandom_range(0, 19))
                0: fill = FILL_ZERO;
                1: fill = FILL_ONES;
                default: fill = FILL_RAND;
            endcase
            full = (ver == l4hfe_pkg::VER_V6) ? 52 : 32;
            if (ver == l4hfe_pkg::VER_NONE)
                n = $urandom_range(1, 40);
            else if ($urandom_range(0, 9) < 6)
                n = full + $urandom_range(0, (ver == l4hfe_pkg::VER_V6) ? 16 : 8);
            else
                n = $urandom_range(1, full - 1);
            maa = 1'b0;
            kind = l4hfe_pkg::KIND_IP;
            close = 1'b1;
            if (r < 72) begin
                // well-formed recordable packet
            end else if (r < 82) begin
                case ($urandom_range(0, 2))
                    0: maa = 1'b1;
                    1: kind = 4'($urandom_range(1, 15));
                    default: begin
                        maa = 1'b1;
                        kind = 4'($urandom_range(1, 15));
                    end
                endcase
            end else if (r < 90) begin
                close = 1'b0;  // cut off by the next first byte
            end else if (r < 95) begin
                n = 0;
                repeat ($urandom_range(1, 3))
                    push_item(8'($urandom), 1'b0, 1'($urandom), 8'($urandom),
                              1'($urandom), 4'($urandom));
            end else begin
                n = 1;
            end
            if (n > 0)
                queue_packet(ver, proto, icmp_t, n, fill, 8'($urandom), maa, kind, close);
            if (close && !maa && kind == l4hfe_pkg::KIND_IP)
                counted += n;
        end
    endtask

    // sender holds off until every queued request is in and every record is out
    task automatic wait_drained();
        while (byte_q.size() != 0 || s_valid || pending_records.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_capture(input logic en);
        logic got;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPTURE_ADDR;
        pwdata <= {31'h0, en};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata[0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== en) begin
            err_cnt++;
            $display("%0t: capture_enable readback expected %0d actual %0d", $time, en, got);
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // capture is off out of reset: nothing recorded
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 32, FILL_RAND, 8'h11,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        wait_drained();
        set_capture(1'b1);

        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 1, FILL_RAND, 8'h5A,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_NONE, 8'h00, 8'h00, 3, FILL_ONES, 8'hFF,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 32, FILL_ONES, 8'hFF,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 32, FILL_ZERO, 8'h00,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_UDP, 8'h00, 34, FILL_RAND, 8'h3C,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_ICMP, l4hfe_pkg::ICMP_ECHO_REQUEST,
                     32, FILL_RAND, 8'h01, 1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_ICMP, 8'd3, 32, FILL_RAND, 8'h02,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V6, l4hfe_pkg::PROTO_ICMP, l4hfe_pkg::ICMP_ECHO_REPLY,
                     52, FILL_RAND, 8'h03, 1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        // longer than the position counter reaches
        queue_packet(l4hfe_pkg::VER_V6, l4hfe_pkg::PROTO_TCP, 8'h00, 68, FILL_ONES, 8'hFE,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V6, l4hfe_pkg::PROTO_UDP, 8'h00, 52, FILL_ZERO, 8'h80,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V6, l4hfe_pkg::PROTO_ICMPV6,
                     l4hfe_pkg::ICMP6_ECHO_REQUEST, 52, FILL_RAND, 8'h04,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_ICMPV6,
                     l4hfe_pkg::ICMP6_ECHO_REPLY, 32, FILL_RAND, 8'h05,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V6, 8'hFF, 8'h00, 60, FILL_RAND, 8'h06,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 25, FILL_RAND, 8'h07,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        push_item(8'hA5, 1'b0, 1'b1, 8'hFF, 1'b1, 4'hF);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_UDP, 8'h00, 10, FILL_RAND, 8'h08,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b0);
        queue_packet(l4hfe_pkg::VER_V6, l4hfe_pkg::PROTO_UDP, 8'h00, 52, FILL_RAND, 8'h09,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 32, FILL_RAND, 8'h0A,
                     1'b1, l4hfe_pkg::KIND_IP, 1'b1);
        queue_packet(l4hfe_pkg::VER_V4, l4hfe_pkg::PROTO_TCP, 8'h00, 32, FILL_RAND, 8'h0B,
                     1'b0, 4'hF, 1'b1);
        queue_packet(l4hfe_pkg::VER_NONE, 8'h00, 8'h00, 8, FILL_ZERO, 8'h81,
                     1'b0, l4hfe_pkg::KIND_IP, 1'b1);
        wait_drained();

        random_traffic(240);
        wait_drained();
        random_traffic(100);
        wait_drained();

        set_capture(1'b0);
        random_traffic(60);
        wait_drained();
        set_capture(1'b1);

        calm = 1'b1;
        random_traffic(170);
        wait_drained();

        $display("summary: %0d packet bytes accepted, %0d log records checked", bytes_seen,
                 recs_seen);
        $display("summary: %0d batch ends seen, capture toggled off and on", batches_seen);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
